// ===== rtl/ble_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery level estimator package
// Widths, reset values, register indexes and voltage limits shared by the
// battery level estimator files.
// ----------------------------------------------------------------------------
`default_nettype none

package ble_pkg;

  localparam int NOW_W      = 32;
  localparam int RAW_W      = 12;
  localparam int MULT_W     = 6;
  localparam int INTERVAL_W = 16;
  localparam int PCT_W      = 7;
  localparam int MV_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MONITOR_ENABLE = 2'd0,
    CFG_ADC_MULTIPLIER = 2'd1,
    CFG_SAMPLE_INTERVAL = 2'd2,
    CFG_DEADBAND = 2'd3
  } cfg_idx_t;

  localparam logic                  RST_MONITOR_ENABLE = 1'b1;
  localparam logic [MULT_W-1:0]     RST_ADC_MULTIPLIER = 6'd2;
  localparam logic [INTERVAL_W-1:0] RST_SAMPLE_INTERVAL = 16'd2000;
  localparam logic [PCT_W-1:0]      RST_DEADBAND = 7'd2;

  localparam logic [MV_W-1:0]  EMPTY_MV = 16'd3400;
  localparam logic [MV_W-1:0]  FULL_MV = 16'd4200;
  localparam logic [MV_W-1:0]  MV_MAX = 16'hFFFF;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam int               MV_PER_PERCENT = (4200 - 3400) / 100;

endpackage : ble_pkg

`default_nettype wire

// ===== rtl/ble_if.sv =====
// ----------------------------------------------------------------------------
// Battery level estimator channels
// Valid/ready channels for sample attempts and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ble_in_if;
  logic                        valid;
  logic                        ready;
  logic [ble_pkg::NOW_W-1:0]   now_ms;
  logic [ble_pkg::RAW_W-1:0]   raw_mv;

  modport source (output valid, output now_ms, output raw_mv, input ready);
  modport sink (input valid, input now_ms, input raw_mv, output ready);
endinterface : ble_in_if

interface ble_out_if;
  logic                        valid;
  logic                        ready;
  logic [ble_pkg::PCT_W-1:0]   level_percent;
  logic [ble_pkg::MV_W-1:0]    filtered_mv;
  logic                        sample_taken;

  modport source (output valid, output level_percent, output filtered_mv,
                  output sample_taken, input ready);
  modport sink (input valid, input level_percent, input filtered_mv,
                input sample_taken, output ready);
endinterface : ble_out_if

`default_nettype wire

// ===== rtl/ble_level_map.sv =====
// ----------------------------------------------------------------------------
// Battery level map
// Maps a filtered voltage onto a percentage between the empty and full
// voltages, truncating and clamping at both ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_level_map (
  input  wire logic [ble_pkg::MV_W-1:0]  mv,
  output logic      [ble_pkg::PCT_W-1:0] pct
);

  logic [ble_pkg::MV_W-1:0] above;
  logic [ble_pkg::MV_W-1:0] steps;

  assign above = mv - ble_pkg::EMPTY_MV;
  assign steps = ble_pkg::MV_W'(above / ble_pkg::MV_PER_PERCENT);

  always_comb begin
    if (mv <= ble_pkg::EMPTY_MV) begin
      pct = '0;
    end else if (steps > ble_pkg::MV_W'(ble_pkg::PCT_MAX)) begin
      pct = ble_pkg::PCT_MAX;
    end else begin
      pct = steps[ble_pkg::PCT_W-1:0];
    end
  end

endmodule : ble_level_map

`default_nettype wire

// ===== rtl/battery_level_estimator_top.sv =====
// ----------------------------------------------------------------------------
// Battery level estimator
// Rate-limited sampling, divider scaling, 3/4 low-pass filter and deadbanded
// percentage report.
// ----------------------------------------------------------------------------
// The block takes one sample beat in every clock cycle unless the result is
// stalled, and returns one result beat for each: the beat is held in an input
// register, and the sampling decision, filter and level update are worked out
// combinationally from there into the result register, which also updates
// the estimator state so that the next beat sees it at once. A stalled result
// holds the pipeline; configuration is written through the plain write port.
`default_nettype none

module battery_level_estimator_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  ble_in_if.sink                               in,
  ble_out_if.source                            out,
  input  wire logic                            cfg_we,
  input  wire logic [ble_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ble_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic                              monitor_enable;
  logic [ble_pkg::MULT_W-1:0]        adc_multiplier;
  logic [ble_pkg::INTERVAL_W-1:0]    sample_interval_ms;
  logic [ble_pkg::PCT_W-1:0]         deadband_percent;

  logic                              pipe_valid;
  logic [ble_pkg::NOW_W-1:0]         pipe_now;
  logic [ble_pkg::RAW_W-1:0]         pipe_raw;

  logic                              out_valid;
  logic [ble_pkg::PCT_W-1:0]         out_level;
  logic [ble_pkg::MV_W-1:0]          out_mv;
  logic                              out_taken;

  logic                              sample_seen, sample_seen_next;
  logic [ble_pkg::NOW_W-1:0]         last_sample_ms, last_sample_ms_next;
  logic [ble_pkg::MV_W-1:0]          smoothed_mv, smoothed_mv_next;
  logic [ble_pkg::PCT_W-1:0]         reported_level, reported_level_next;
  logic                              level_valid, level_valid_next;

  logic                              advance;
  logic                              fire;
  logic [ble_pkg::NOW_W-1:0]         elapsed;
  logic                              attempt;
  logic                              take;
  logic [17:0]                       product;
  logic [ble_pkg::MV_W-1:0]          scaled;
  logic [17:0]                       blend;
  logic [ble_pkg::MV_W-1:0]          filter_mv;
  logic [ble_pkg::PCT_W-1:0]         new_pct;
  logic [ble_pkg::PCT_W-1:0]         delta;
  logic                              level_update;
  logic [ble_pkg::PCT_W-1:0]         level_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_enable     <= ble_pkg::RST_MONITOR_ENABLE;
      adc_multiplier     <= ble_pkg::RST_ADC_MULTIPLIER;
      sample_interval_ms <= ble_pkg::RST_SAMPLE_INTERVAL;
      deadband_percent   <= ble_pkg::RST_DEADBAND;
    end else if (cfg_we) begin
      unique case (ble_pkg::cfg_idx_t'(cfg_index))
        ble_pkg::CFG_MONITOR_ENABLE: monitor_enable <= cfg_wdata[0];
        ble_pkg::CFG_ADC_MULTIPLIER: adc_multiplier <= cfg_wdata[ble_pkg::MULT_W-1:0];
        ble_pkg::CFG_SAMPLE_INTERVAL: sample_interval_ms <= cfg_wdata;
        ble_pkg::CFG_DEADBAND: deadband_percent <= cfg_wdata[ble_pkg::PCT_W-1:0];
      endcase
    end
  end

  assign advance  = !out_valid || out.ready;
  assign in.ready = !pipe_valid || advance;
  assign fire     = pipe_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (in.ready) begin
      pipe_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.ready && in.valid) begin
      pipe_now <= in.now_ms;
      pipe_raw <= in.raw_mv;
    end
  end

  assign elapsed = pipe_now - last_sample_ms;
  assign attempt = monitor_enable &&
                   (!sample_seen || elapsed >= ble_pkg::NOW_W'(sample_interval_ms));
  assign take    = attempt && (pipe_raw != '0);

  assign product = 18'(pipe_raw) * 18'(adc_multiplier);
  assign scaled  = (product > 18'(ble_pkg::MV_MAX)) ? ble_pkg::MV_MAX : product[15:0];
  assign blend   = 18'(smoothed_mv) * 18'd3 + 18'(scaled);
  assign filter_mv = (smoothed_mv == '0) ? scaled : blend[17:2];

  ble_level_map u_level_map (
    .mv  (filter_mv),
    .pct (new_pct)
  );

  assign delta = (new_pct > reported_level) ? (new_pct - reported_level)
                                            : (reported_level - new_pct);
  assign level_update = !level_valid || (delta >= deadband_percent);

  always_comb begin
    sample_seen_next    = sample_seen || attempt;
    last_sample_ms_next = attempt ? pipe_now : last_sample_ms;
    smoothed_mv_next    = take ? filter_mv : smoothed_mv;
    reported_level_next = (take && level_update) ? new_pct : reported_level;
    level_valid_next    = level_valid || take;
  end

  assign level_out = (monitor_enable && level_valid_next) ? reported_level_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_seen    <= 1'b0;
      last_sample_ms <= '0;
      smoothed_mv    <= '0;
      reported_level <= '0;
      level_valid    <= 1'b0;
    end else if (fire) begin
      sample_seen    <= sample_seen_next;
      last_sample_ms <= last_sample_ms_next;
      smoothed_mv    <= smoothed_mv_next;
      reported_level <= reported_level_next;
      level_valid    <= level_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_level <= level_out;
      out_mv    <= smoothed_mv_next;
      out_taken <= take;
    end
  end

  assign out.valid         = out_valid;
  assign out.level_percent = out_level;
  assign out.filtered_mv   = out_mv;
  assign out.sample_taken  = out_taken;

  a_level_needs_sample: assert property (@(posedge clk) disable iff (rst)
    level_valid |-> sample_seen)
    else $error("level held without any sample taken");

  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    reported_level <= ble_pkg::PCT_MAX)
    else $error("reported level above full scale");

  a_result_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pipe_valid))
    else $error("result beat without a held sample beat");

  a_accept_fills_pipe: assert property (@(posedge clk) disable iff (rst)
    (in.valid && in.ready) |=> pipe_valid)
    else $error("accepted beat lost before processing");

  a_state_frozen_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(smoothed_mv) && $stable(last_sample_ms))
    else $error("estimator state changed while the result was stalled");

endmodule : battery_level_estimator_top

`default_nettype wire
